// File: rtl/cpp_pkg.sv
// shared types and constants for the closest point on polyline block
package cpp_pkg;

   localparam int DEFAULT_MAX_VERTICES = 64;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int NUM_W   = 68;
   localparam int DEN_W   = 67;
   localparam int QUO_W   = 33;
   localparam int BIG_W   = DEN_W + QUO_W;
   localparam int MUL_W   = 35;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int VC_W    = 7;
   localparam int FRAC_W  = 17;
   localparam int SEG_W   = 6;

   localparam logic [VC_W-1:0]  VC_RESET = VC_W'(2);
   localparam logic [DEN_W-1:0] DIST_CAP = DEN_W'(64'd10000 << 32);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] TAG_FRAC = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [1:0]       tag;
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } div_data_type;

endpackage

// File: rtl/closest_point_on_polyline.sv
// top level: vertex table, segment sequencer, shared multiplier and division chain
// a vertex write goes into the vertex table on its transfer; a query's result strobe comes
// after its last segment and any fraction division, and the next transfer can be taken in that strobe cycle
// each projected segment waits on the division chain, the fraction once more, and
// the single multiplier forms 15 products per projected segment; the receiver cannot stall
// reset clears control state and sets vertex_count to 2; the vertex table is undefined
module closest_point_on_polyline #(
   parameter int MAX_VERTICES = cpp_pkg::DEFAULT_MAX_VERTICES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [5:0]                          req_vertex_index,
   input  logic signed [cpp_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [cpp_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [cpp_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                rsp_valid,
   output logic signed [cpp_pkg::COORD_W-1:0]  rsp_nearest_x,
   output logic signed [cpp_pkg::COORD_W-1:0]  rsp_nearest_y,
   output logic signed [cpp_pkg::COORD_W-1:0]  rsp_nearest_z,
   output logic [cpp_pkg::SEG_W-1:0]           rsp_segment_index,
   output logic [cpp_pkg::FRAC_W-1:0]          rsp_fraction_completed,
   output logic                                rsp_found,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [1:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = cpp_pkg::COORD_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD0  = 4'd1;
   localparam logic [3:0] ST_RD1  = 4'd2;
   localparam logic [3:0] ST_SUB  = 4'd3;
   localparam logic [3:0] ST_ND   = 4'd4;
   localparam logic [3:0] ST_DEC  = 4'd5;
   localparam logic [3:0] ST_PN   = 4'd6;
   localparam logic [3:0] ST_DV   = 4'd7;
   localparam logic [3:0] ST_DW   = 4'd8;
   localparam logic [3:0] ST_DIST = 4'd9;
   localparam logic [3:0] ST_CMP  = 4'd10;
   localparam logic [3:0] ST_NEXT = 4'd11;
   localparam logic [3:0] ST_FRAC = 4'd12;
   localparam logic [3:0] ST_FW   = 4'd13;
   localparam logic [3:0] ST_OUT  = 4'd14;

   logic [3:0]                        state_ff, state_in;
   logic [2:0]                        cnt_ff, cnt_in;
   logic [cpp_pkg::VC_W-1:0]          vc_ff, vc_in;
   logic signed [CW-1:0]              q_ff [3], q_in [3];
   logic signed [CW-1:0]              p1_ff [3], p1_in [3];
   logic signed [CW-1:0]              p2_ff [3], p2_in [3];
   logic signed [CW-1:0]              c_ff [3], c_in [3];
   logic signed [CW-1:0]              best_c_ff [3], best_c_in [3];
   logic signed [cpp_pkg::DIFF_W-1:0] d_ff [3], d_in [3];
   logic signed [cpp_pkg::DIFF_W-1:0] v_ff [3], v_in [3];
   logic [cpp_pkg::BIG_W-1:0]         nbig_ff [3], nbig_in [3];
   logic signed [cpp_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [cpp_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [cpp_pkg::DEN_W-1:0]         dist_ff, dist_in;
   logic [cpp_pkg::DEN_W-1:0]         best_dist_ff, best_dist_in;
   logic [IW-1:0]                     best_idx_ff, best_idx_in;
   logic                              found_ff, found_in;
   logic [IW-1:0]                     seg_ff, seg_in;
   logic [IW-1:0]                     segs_ff, segs_in;
   logic [cpp_pkg::FRAC_W-1:0]        frac_ff, frac_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]              rsp_c_ff [3], rsp_c_in [3];
   logic [cpp_pkg::SEG_W-1:0]         rsp_seg_ff, rsp_seg_in;
   logic [cpp_pkg::FRAC_W-1:0]        rsp_frac_ff, rsp_frac_in;
   logic                              rsp_found_ff, rsp_found_in;

   logic [3*CW-1:0]                   mem [MAX_VERTICES];
   logic [3*CW-1:0]                   rdata_ff;
   logic [IW-1:0]                     rd_addr;
   logic signed [CW-1:0]              rv [3];
   logic                              wr_en;
   logic [15:0]                       slot_w;

   logic signed [cpp_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [cpp_pkg::PROD_W-1:0] prod_ff;
   logic [cpp_pkg::DIFF_W-1:0]        dm [3];
   logic signed [cpp_pkg::DIFF_W-1:0] e [3];

   cpp_pkg::div_data_type             div_in, div_out;

   logic                              accept;
   logic [15:0]                       vc16, n16;
   logic [2:0]                        j;
   logic [cpp_pkg::QUO_W-1:0]         quo;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;
   assign pready = 1'b1;
   assign prdata = 32'(vc_ff);

   assign slot_w = 16'(req_vertex_index);
   assign wr_en  = accept && req_operation == cpp_pkg::OP_WRITE &&
                   int'(slot_w) < MAX_VERTICES;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot_w[IW-1:0]] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rv[k] = rdata_ff[CW*k +: CW];
         dm[k] = d_ff[k][cpp_pkg::DIFF_W-1] ? cpp_pkg::DIFF_W'(-d_ff[k])
                                            : cpp_pkg::DIFF_W'(d_ff[k]);
         e[k]  = cpp_pkg::DIFF_W'(c_ff[k]) - cpp_pkg::DIFF_W'(q_ff[k]);
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ND: begin
            if (cnt_ff < 3'd3) begin
               mul_a = cpp_pkg::MUL_W'(v_ff[cnt_ff[1:0]]);
               mul_b = cpp_pkg::MUL_W'(d_ff[cnt_ff[1:0]]);
            end else if (cnt_ff < 3'd6) begin
               mul_a = cpp_pkg::MUL_W'(d_ff[2'(cnt_ff - 3'd3)]);
               mul_b = cpp_pkg::MUL_W'(d_ff[2'(cnt_ff - 3'd3)]);
            end
         end
         ST_PN: begin
            if (cnt_ff < 3'd6) begin
               mul_a = cpp_pkg::MUL_W'(dm[cnt_ff[2:1]]);
               mul_b = cnt_ff[0] ? cpp_pkg::MUL_W'(num_ff[65:34])
                                 : cpp_pkg::MUL_W'(num_ff[33:0]);
            end
         end
         ST_DIST: begin
            if (cnt_ff < 3'd3) begin
               mul_a = cpp_pkg::MUL_W'(e[cnt_ff[1:0]]);
               mul_b = cpp_pkg::MUL_W'(e[cnt_ff[1:0]]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   cpp_div_chain u_div_chain (
      .clock     (clock),
      .reset     (reset),
      .chain_in  (div_in),
      .chain_out (div_out)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vc_in        = vc_ff;
      q_in         = q_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      c_in         = c_ff;
      best_c_in    = best_c_ff;
      d_in         = d_ff;
      v_in         = v_ff;
      nbig_in      = nbig_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      dist_in      = dist_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      seg_in       = seg_ff;
      segs_in      = segs_ff;
      frac_in      = frac_ff;
      rsp_valid_in = 1'b0;
      rsp_c_in     = rsp_c_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_found_in = rsp_found_ff;
      rd_addr      = IW'(seg_ff + 1'b1);
      div_in       = '0;
      j            = cnt_ff - 3'd1;
      quo          = div_out.quo;

      vc16 = 16'(vc_ff);
      if (vc16 < 16'd2) begin
         n16 = 16'd2;
      end else if (vc16 > 16'(MAX_VERTICES)) begin
         n16 = 16'(MAX_VERTICES);
      end else begin
         n16 = vc16;
      end

      if (psel && penable && pwrite) begin
         vc_in = pwdata[cpp_pkg::VC_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == cpp_pkg::OP_QUERY) begin
               q_in[0]      = req_coord_x;
               q_in[1]      = req_coord_y;
               q_in[2]      = req_coord_z;
               seg_in       = '0;
               segs_in      = IW'(n16 - 16'd1);
               best_dist_in = cpp_pkg::DIST_CAP;
               best_idx_in  = '0;
               found_in     = 1'b0;
               frac_in      = '0;
               for (int k = 0; k < 3; k++) begin
                  best_c_in[k] = '0;
               end
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            rd_addr  = '0;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            p1_in    = rv;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            for (int k = 0; k < 3; k++) begin
               p2_in[k] = rv[k];
               d_in[k]  = cpp_pkg::DIFF_W'(rv[k]) - cpp_pkg::DIFF_W'(p1_ff[k]);
               v_in[k]  = cpp_pkg::DIFF_W'(q_ff[k]) - cpp_pkg::DIFF_W'(p1_ff[k]);
            end
            num_in   = '0;
            den_in   = '0;
            cnt_in   = '0;
            state_in = ST_ND;
         end
         ST_ND: begin
            if (cnt_ff != 3'd0) begin
               if (j < 3'd3) begin
                  num_in = num_ff + cpp_pkg::NUM_W'(prod_ff);
               end else begin
                  den_in = den_ff + prod_ff[cpp_pkg::DEN_W-1:0];
               end
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            cnt_in  = '0;
            dist_in = '0;
            priority if (num_ff[cpp_pkg::NUM_W-1] || num_ff == '0) begin
               c_in     = p1_ff;
               state_in = ST_DIST;
            end else if (num_ff[cpp_pkg::DEN_W-1:0] >= den_ff) begin
               c_in     = p2_ff;
               state_in = ST_DIST;
            end else begin
               state_in = ST_PN;
            end
         end
         ST_PN: begin
            if (cnt_ff != 3'd0) begin
               if (j[0] == 1'b0) begin
                  nbig_in[j[2:1]] = cpp_pkg::BIG_W'(prod_ff[cpp_pkg::DEN_W-1:0]);
               end else begin
                  nbig_in[j[2:1]] = nbig_ff[j[2:1]] + {prod_ff[65:0], 34'b0};
               end
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               cnt_in   = '0;
               state_in = ST_DV;
            end
         end
         ST_DV: begin
            div_in.valid = 1'b1;
            div_in.tag   = cnt_ff[1:0];
            div_in.rem   = nbig_ff[cnt_ff[1:0]][cpp_pkg::BIG_W-1:cpp_pkg::QUO_W];
            div_in.low   = nbig_ff[cnt_ff[1:0]][cpp_pkg::QUO_W-1:0];
            div_in.den   = den_ff;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) begin
               state_in = ST_DW;
            end
         end
         ST_DW: begin
            if (div_out.valid && div_out.tag == 2'd2) begin
               cnt_in   = '0;
               dist_in  = '0;
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (cnt_ff != 3'd0) begin
               dist_in = dist_ff + prod_ff[cpp_pkg::DEN_W-1:0];
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (dist_ff < best_dist_ff) begin
               best_dist_in = dist_ff;
               best_c_in    = c_ff;
               best_idx_in  = seg_ff;
               found_in     = 1'b1;
            end
            if (seg_ff == IW'(segs_ff - 1'b1)) begin
               state_in = ST_FRAC;
            end else begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            p1_in    = p2_ff;
            state_in = ST_SUB;
         end
         ST_FRAC: begin
            if (found_ff && segs_ff > IW'(1)) begin
               div_in.valid = 1'b1;
               div_in.tag   = cpp_pkg::TAG_FRAC;
               div_in.rem   = '0;
               div_in.low   = cpp_pkg::QUO_W'({best_idx_ff, 16'b0});
               div_in.den   = cpp_pkg::DEN_W'(segs_ff - 1'b1);
               state_in     = ST_FW;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FW: begin
            if (div_out.valid && div_out.tag == cpp_pkg::TAG_FRAC) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_c_in     = best_c_ff;
            rsp_seg_in   = cpp_pkg::SEG_W'(best_idx_ff);
            rsp_frac_in  = frac_ff;
            rsp_found_in = found_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // division results return in order
      if (div_out.valid) begin
         if (div_out.tag == cpp_pkg::TAG_FRAC) begin
            frac_in = quo[cpp_pkg::FRAC_W-1:0];
         end else if (d_ff[div_out.tag][cpp_pkg::DIFF_W-1]) begin
            c_in[div_out.tag] = p1_ff[div_out.tag] - quo[CW-1:0];
         end else begin
            c_in[div_out.tag] = p1_ff[div_out.tag] + quo[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         vc_ff        <= cpp_pkg::VC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      c_ff         <= c_in;
      best_c_ff    <= best_c_in;
      d_ff         <= d_in;
      v_ff         <= v_in;
      nbig_ff      <= nbig_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      dist_ff      <= dist_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      found_ff     <= found_in;
      seg_ff       <= seg_in;
      segs_ff      <= segs_in;
      frac_ff      <= frac_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_nearest_x          = rsp_c_ff[0];
   assign rsp_nearest_y          = rsp_c_ff[1];
   assign rsp_nearest_z          = rsp_c_ff[2];
   assign rsp_segment_index      = rsp_seg_ff;
   assign rsp_fraction_completed = rsp_frac_ff;
   assign rsp_found              = rsp_found_ff;

endmodule

// File: rtl/cpp_div_cell.sv
// one restoring division step, registered
module cpp_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cpp_pkg::div_data_type cell_in,
   output cpp_pkg::div_data_type cell_out
);

   logic                          valid_ff;
   cpp_pkg::div_data_type         data_ff;
   cpp_pkg::div_data_type         data_in;
   logic [cpp_pkg::DEN_W:0]       trial;
   logic                          ge;

   always_comb begin
      trial   = {cell_in.rem, cell_in.low[cpp_pkg::QUO_W-1]};
      ge      = trial >= (cpp_pkg::DEN_W + 1)'(cell_in.den);
      data_in = cell_in;
      data_in.rem = ge ? cpp_pkg::DEN_W'(trial - (cpp_pkg::DEN_W + 1)'(cell_in.den))
                       : trial[cpp_pkg::DEN_W-1:0];
      data_in.low = {cell_in.low[cpp_pkg::QUO_W-2:0], 1'b0};
      data_in.quo = {cell_in.quo[cpp_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

// File: rtl/cpp_div_chain.sv
// row of division cells, one quotient bit per cell
module cpp_div_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  cpp_pkg::div_data_type chain_in,
   output cpp_pkg::div_data_type chain_out
);

   cpp_pkg::div_data_type link [cpp_pkg::QUO_W+1];

   assign link[0] = chain_in;

   for (genvar i = 0; i < cpp_pkg::QUO_W; i++) begin : g_cell
      cpp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (link[i]),
         .cell_out (link[i+1])
      );
   end

   assign chain_out = link[cpp_pkg::QUO_W];

endmodule
